// File: sv/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Holds the capacity, the field widths, the operation and status codes, and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_INSERT_AT  = 3'd2,
    K_POP_FRONT  = 3'd3,
    K_POP_BACK   = 3'd4,
    K_REMOVE_AT  = 3'd5,
    K_DUMP       = 3'd6,
    K_CLEAR      = 3'd7
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef struct packed {
    logic apply;
    logic dump_start;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic dump_at_end;
  } stat_t;

endpackage

// File: sv/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list: ordered list of up to CAPACITY signed 32-bit values
// Top level joining the controller and the shifting-cell datapath.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. For every
// operation but dump, its single result is on the out_ ports, marked by
// out_valid, in the cycle after it was taken, and busy stays low so a new
// item may follow at once, since all cells shift in parallel. A dump raises
// busy while the read index walks the cells one a cycle, up to count; its
// results appear on consecutive cycles once the controller is in its dump
// state, each taken into the result registers, the terminator last. Results
// are strobed for one cycle and the receiver cannot stall them.
module bounded_ordered_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bol_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bol_pkg::VAL_W-1:0]  in_value,
  input  logic [bol_pkg::CNT_W-1:0]         in_position,
  output logic                              out_valid,
  output logic signed [bol_pkg::VAL_W-1:0]  out_item_value,
  output logic                              out_is_end,
  output logic [bol_pkg::STAT_W-1:0]        out_status,
  output logic [bol_pkg::CNT_W-1:0]         out_count,
  output logic                              out_is_empty,
  output logic                              out_last
);
  import bol_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bol_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bol_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_is_end     (out_is_end),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_last       (out_last)
  );

endmodule

// File: sv/bol_ctrl.sv
// ----------------------------------------------------------------------------
// bol_ctrl: controller of the bounded ordered list
// Accepts items, issues update and dump commands to the datapath and keeps
// the block busy while a dump walks the list.
// ----------------------------------------------------------------------------
module bol_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bol_pkg::KIND_W-1:0] in_kind,
  input  bol_pkg::stat_t             stat,
  output bol_pkg::cmd_t              cmd,
  output logic                       busy
);
  import bol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (kind_t'(in_kind) == K_DUMP) begin
            cmd.dump_start = 1'b1;
            state_nxt      = S_DUMP;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      S_DUMP: begin
        cmd.dump_step = 1'b1;
        if (stat.dump_at_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/bol_dpath.sv
// ----------------------------------------------------------------------------
// bol_dpath: datapath of the bounded ordered list
// A row of cells that shift in parallel on insert and remove, the element
// count, the dump read index and the registered result ports.
// ----------------------------------------------------------------------------
module bol_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bol_pkg::cmd_t                     cmd,
  output bol_pkg::stat_t                    stat,
  input  logic [bol_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bol_pkg::VAL_W-1:0]  in_value,
  input  logic [bol_pkg::CNT_W-1:0]         in_position,
  output logic                              out_valid,
  output logic signed [bol_pkg::VAL_W-1:0]  out_item_value,
  output logic                              out_is_end,
  output logic [bol_pkg::STAT_W-1:0]        out_status,
  output logic [bol_pkg::CNT_W-1:0]         out_count,
  output logic                              out_is_empty,
  output logic                              out_last
);
  import bol_pkg::*;

  logic signed [VAL_W-1:0] cells_r   [CAPACITY];
  logic signed [VAL_W-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    is_ins, is_rem, is_clr;
  logic [CNT_W-1:0]        ins_pos, rem_pos;
  status_t                 op_status;
  logic                    at_end;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_item_value_r;
  logic                    out_is_end_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_last_r;

  assign at_end           = (rd_idx_r == count_r);
  assign stat.dump_at_end = at_end;

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_clr  = 1'b0;
    ins_pos = '0;
    rem_pos = '0;
    unique case (kind_t'(in_kind))
      K_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      K_PUSH_BACK: begin
        is_ins  = 1'b1;
        ins_pos = count_r;
      end
      K_INSERT_AT: begin
        is_ins  = 1'b1;
        ins_pos = in_position;
      end
      K_POP_FRONT: begin
        is_rem = 1'b1;
      end
      K_POP_BACK: begin
        is_rem  = 1'b1;
        rem_pos = count_r - CNT_W'(1);
      end
      K_REMOVE_AT: begin
        is_rem  = 1'b1;
        rem_pos = in_position;
      end
      K_CLEAR: begin
        is_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cells_nxt = cells_r;
    count_nxt = count_r;
    op_status = ST_OK;
    if (is_ins) begin
      if (count_r >= CNT_W'(CAPACITY)) begin
        op_status = ST_FULL;
      end else if (ins_pos > count_r) begin
        op_status = ST_BAD_POS;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == ins_pos) begin
            cells_nxt[i] = in_value;
          end else if (i > 0 && CNT_W'(i) > ins_pos) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_rem) begin
      if (count_r == '0) begin
        op_status = ST_EMPTY;
      end else if (rem_pos >= count_r) begin
        op_status = ST_BAD_POS;
      end else begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (CNT_W'(i) >= rem_pos) begin
            cells_nxt[i] = cells_r[i + 1];
          end
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (is_clr) begin
      count_nxt = '0;
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.dump_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.dump_step) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        count_r <= count_nxt;
      end
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= cmd.apply || cmd.dump_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      cells_r <= cells_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_item_value_r <= '0;
      out_is_end_r     <= 1'b0;
      out_status_r     <= op_status;
      out_count_r      <= count_nxt;
      out_last_r       <= 1'b1;
    end else if (cmd.dump_step) begin
      out_item_value_r <= at_end ? '0 : cells_r[rd_idx_r[IDX_W-1:0]];
      out_is_end_r     <= at_end;
      out_status_r     <= ST_OK;
      out_count_r      <= count_r;
      out_last_r       <= at_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_value = out_item_value_r;
  assign out_is_end     = out_is_end_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = (out_count_r == '0);
  assign out_last       = out_last_r;

endmodule

// File: sv/bol_checker.sv
// ----------------------------------------------------------------------------
// bol_checker: port-level checks of the bounded ordered list
// Watches the top level's ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
module bol_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [bol_pkg::KIND_W-1:0]        in_kind,
  input logic                              out_valid,
  input logic signed [bol_pkg::VAL_W-1:0]  out_item_value,
  input logic                              out_is_end,
  input logic [bol_pkg::STAT_W-1:0]        out_status,
  input logic [bol_pkg::CNT_W-1:0]         out_count,
  input logic                              out_is_empty,
  input logic                              out_last
);
  import bol_pkg::*;

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && kind_t'(in_kind) != K_DUMP)
      |=> (out_valid && out_last && !out_is_end))
    else $error("Update item did not give its result in the next cycle.");

  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && kind_t'(in_kind) == K_DUMP) |=> (busy && !out_valid))
    else $error("Dump item did not hold the block busy.");

  a_dump_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("Dump results are not on consecutive cycles.");

  a_terminator: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end)
      |-> (out_last && status_t'(out_status) == ST_OK && out_item_value == '0))
    else $error("Dump terminator has wrong fields.");

  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_is_empty == (out_count == '0)) &&
                   (out_count <= CNT_W'(CAPACITY))))
    else $error("Result count and empty flag disagree.");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_item_value (out_item_value),
  .out_is_end     (out_is_end),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_is_empty   (out_is_empty),
  .out_last       (out_last)
);
